@@ rtl/tvb_pkg.sv @@
package tvb_pkg;

  localparam int NUM_REGS  = 6;
  localparam int REG_IDX_W = 3;
  localparam int REG_W     = 64;
  localparam int MAT_W     = 32;
  localparam int POS_W     = 32;
  localparam int OUT_W     = 32;
  localparam int AXES      = 3;

  // identity matrix, no translation
  localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000
  };

  typedef struct packed {
    logic first;
    logic last;
  } vtx_flags_t;

endpackage

@@ rtl/tvb_xform.sv @@
module tvb_xform #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_we,
  input  logic [tvb_pkg::REG_IDX_W-1:0]              cfg_index,
  input  logic [tvb_pkg::REG_W-1:0]                  cfg_data,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic [tvb_pkg::AXES*tvb_pkg::POS_W-1:0]    in_pos,
  input  tvb_pkg::vtx_flags_t                        in_flags,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic [tvb_pkg::AXES*COORD_BITS-1:0]        out_coord,
  output tvb_pkg::vtx_flags_t                        out_flags
);

  localparam int AXES  = tvb_pkg::AXES;
  localparam int MAT_W = tvb_pkg::MAT_W;
  localparam int POS_W = tvb_pkg::POS_W;
  localparam int PROD_W = MAT_W + POS_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = ~C_MAX;

  logic [tvb_pkg::REG_W-1:0] cfg_reg [tvb_pkg::NUM_REGS];

  logic signed [MAT_W-1:0] mat [AXES][AXES+1];
  logic signed [POS_W-1:0] pos [AXES];

  logic                      v1, v2, v3;
  tvb_pkg::vtx_flags_t       f1, f2, f3;
  logic signed [PROD_W-1:0]  prod [AXES][AXES];
  logic signed [SUM_W-1:0]   trans [AXES];
  logic signed [SUM_W-1:0]   sum [AXES];
  logic signed [SUM_W-1:0]   shifted [AXES];
  logic signed [COORD_BITS-1:0] sat [AXES];
  logic signed [COORD_BITS-1:0] coord [AXES];
  logic                      ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tvb_pkg::NUM_REGS; i++) begin
        cfg_reg[i] <= tvb_pkg::REG_RESET[i];
      end
    end else if (cfg_we && (cfg_index < tvb_pkg::REG_IDX_W'(tvb_pkg::NUM_REGS))) begin
      cfg_reg[cfg_index] <= cfg_data;
    end
  end

  // row r lives in two registers, even column in the low half
  always_comb begin
    for (int r = 0; r < AXES; r++) begin
      for (int c = 0; c <= AXES; c++) begin
        mat[r][c] = signed'(cfg_reg[2*r + (c >> 1)][(c & 1)*MAT_W +: MAT_W]);
      end
    end
    for (int a = 0; a < AXES; a++) begin
      pos[a] = signed'(in_pos[a*POS_W +: POS_W]);
    end
  end

  assign ce       = !v3 || out_ready;
  assign in_ready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // floor to the integer grid and clamp to the coordinate range
  always_comb begin
    for (int r = 0; r < AXES; r++) begin
      shifted[r] = sum[r] >>> FRAC_BITS;
      if (shifted[r][SUM_W-1]) begin
        if (&shifted[r][SUM_W-1:COORD_BITS-1]) begin
          sat[r] = shifted[r][COORD_BITS-1:0];
        end else begin
          sat[r] = C_MIN;
        end
      end else begin
        if (|shifted[r][SUM_W-1:COORD_BITS-1]) begin
          sat[r] = C_MAX;
        end else begin
          sat[r] = shifted[r][COORD_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f1 <= in_flags;
      f2 <= f1;
      f3 <= f2;
      for (int r = 0; r < AXES; r++) begin
        for (int c = 0; c < AXES; c++) begin
          prod[r][c] <= mat[r][c] * pos[c];
        end
        trans[r] <= SUM_W'(mat[r][AXES]) <<< FRAC_BITS;
        sum[r]   <= SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]) + SUM_W'(prod[r][2]) + trans[r];
        coord[r] <= sat[r];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      out_coord[a*COORD_BITS +: COORD_BITS] = coord[a];
    end
  end

  assign out_valid = v3;
  assign out_flags = f3;

endmodule

@@ rtl/tvb_fifo.sv @@
module tvb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/tvb_bounds.sv @@
module tvb_bounds #(
  parameter int COORD_BITS = 32
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  input  logic [tvb_pkg::AXES*COORD_BITS-1:0]          in_coord,
  input  tvb_pkg::vtx_flags_t                          in_flags,
  output logic                                         pop,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [2*tvb_pkg::AXES*tvb_pkg::OUT_W-1:0]    out_data
);

  localparam int AXES  = tvb_pkg::AXES;
  localparam int OUT_W = tvb_pkg::OUT_W;
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = ~C_MAX;

  logic signed [COORD_BITS-1:0] low_corner [AXES];
  logic signed [COORD_BITS-1:0] high_corner [AXES];
  logic signed [COORD_BITS-1:0] low_next [AXES];
  logic signed [COORD_BITS-1:0] high_next [AXES];
  logic signed [COORD_BITS-1:0] base_lo, base_hi, v;
  logic                         emit;

  // a vertex that closes a mesh waits until the output register is free
  assign pop  = in_valid && (!in_flags.last || !out_valid || out_ready);
  assign emit = pop && in_flags.last;

  always_comb begin
    base_lo = C_MAX;
    base_hi = C_MIN;
    v       = '0;
    for (int a = 0; a < AXES; a++) begin
      v       = signed'(in_coord[a*COORD_BITS +: COORD_BITS]);
      base_lo = in_flags.first ? C_MAX : low_corner[a];
      base_hi = in_flags.first ? C_MIN : high_corner[a];
      low_next[a]  = (v < base_lo) ? v : base_lo;
      high_next[a] = (v > base_hi) ? v : base_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        low_corner[a]  <= C_MAX;
        high_corner[a] <= C_MIN;
      end
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        for (int a = 0; a < AXES; a++) begin
          low_corner[a]  <= low_next[a];
          high_corner[a] <= high_next[a];
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      for (int a = 0; a < AXES; a++) begin
        out_data[a*OUT_W +: OUT_W]        <= OUT_W'(low_next[a]);
        out_data[(a+AXES)*OUT_W +: OUT_W] <= OUT_W'(high_next[a]);
      end
    end
  end

endmodule

@@ rtl/transformed_vertex_bounds.sv @@
// transformed vertex bounds: running axis-aligned box of vertices after an affine transform
//
// slave stream: one vertex per transfer, pos_x/pos_y/pos_z in tdata, the first
// flag in tuser and the last flag in tlast. master stream: one transfer of six
// bounds for every vertex that carries the last flag.
// the matrix is written through cfg_we/cfg_index/cfg_data; the user must write it only
// while idle, which the block does not enforce; indexes beyond the six registers are dropped.
// throughput is one vertex per cycle while s_axis_tready is high: nine 32x32 multipliers
// feed a three-stage transform pipeline, and only the min/max update carries state.
// a last vertex accepted at the slave side passes the product, sum and round/clamp
// registers in that order, is then written into the queue, and the bounds register
// then raises tvalid on the master side.
// a four-entry queue sits between transform and bounds update; s_axis_tready
// drops only when that queue is full and the last transform stage is holding a vertex.
// a stalled master holds its result; further vertices keep flowing until a
// second last vertex reaches the head of the queue.
// reset loads the identity matrix, opens the bounds to the empty box and
// clears the pipeline and queue; no clearing pass is needed.
module transformed_vertex_bounds #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tvb_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [tvb_pkg::REG_W-1:0]         cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [95:0]                       s_axis_tdata,   // pos_x, pos_y, pos_z
  input  logic                              s_axis_tuser,   // first_vertex
  input  logic                              s_axis_tlast,   // last_vertex
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [191:0]                      m_axis_tdata    // min_x, min_y, min_z, max_x, max_y, max_z
);

  localparam int AXES    = tvb_pkg::AXES;
  localparam int COORD_W = AXES * COORD_BITS;
  localparam int ENTRY_W = COORD_W + $bits(tvb_pkg::vtx_flags_t);
  localparam int Q_DEPTH = 4;

  tvb_pkg::vtx_flags_t  in_flags, x_flags, head_flags;
  logic                 x_valid, fifo_full, fifo_empty, pop;
  logic [COORD_W-1:0]   x_coord, head_coord;
  logic [ENTRY_W-1:0]   head_entry;

  assign in_flags.first = s_axis_tuser;
  assign in_flags.last  = s_axis_tlast;

  tvb_xform #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_xform (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_pos   (s_axis_tdata),
    .in_flags (in_flags),
    .out_valid(x_valid),
    .out_ready(!fifo_full),
    .out_coord(x_coord),
    .out_flags(x_flags)
  );

  tvb_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(Q_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (x_valid && !fifo_full),
    .push_data({x_flags, x_coord}),
    .full     (fifo_full),
    .pop      (pop),
    .pop_data (head_entry),
    .empty    (fifo_empty)
  );

  assign head_coord = head_entry[COORD_W-1:0];
  assign head_flags = head_entry[ENTRY_W-1:COORD_W];

  tvb_bounds #(
    .COORD_BITS(COORD_BITS)
  ) u_bounds (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!fifo_empty),
    .in_coord (head_coord),
    .in_flags (head_flags),
    .pop      (pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata)
  );

  // the front only stalls on a full queue
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> fifo_full)
    else $error("input stalled while the queue had room");

  // a new result comes only from a popped last vertex
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(pop && head_flags.last))
    else $error("result raised without a last vertex");

  // every emitted box holds at least one vertex
  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (COORD_BITS <= 32)) |->
      (signed'(m_axis_tdata[31:0])  <= signed'(m_axis_tdata[127:96])) &&
      (signed'(m_axis_tdata[63:32]) <= signed'(m_axis_tdata[159:128])) &&
      (signed'(m_axis_tdata[95:64]) <= signed'(m_axis_tdata[191:160])))
    else $error("emitted minimum above maximum");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int FRAC          = 16;
  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 150;

  localparam logic signed [79:0] SAT_HI = 80'sh7FFF_FFFF;
  localparam logic signed [79:0] SAT_LO = -80'sh8000_0000;

  typedef struct packed {
    tvb_pkg::vtx_flags_t flags;
    logic [31:0]         z;
    logic [31:0]         y;
    logic [31:0]         x;
  } vertex_t;

  // declared high to low so that the packed value lines up with m_axis_tdata
  typedef struct packed {
    logic [31:0] max_z;
    logic [31:0] max_y;
    logic [31:0] max_x;
    logic [31:0] min_z;
    logic [31:0] min_y;
    logic [31:0] min_x;
  } box_t;

  typedef struct {
    vertex_t v;
    int      mat;
    bit      typed;
    box_t    box;
  } row_t;

  logic                          clk;
  logic                          rst           = 1'b1;
  logic                          cfg_we        = 1'b0;
  logic [tvb_pkg::REG_IDX_W-1:0] cfg_index     = '0;
  logic [tvb_pkg::REG_W-1:0]     cfg_data      = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [95:0]                   s_axis_tdata  = '0;   // pos_x, pos_y, pos_z
  logic                          s_axis_tuser  = 1'b0; // first_vertex
  logic                          s_axis_tlast  = 1'b0; // last_vertex
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b1;
  logic [191:0]                  m_axis_tdata;  // min_x, min_y, min_z, max_x, max_y, max_z

  transformed_vertex_bounds #(
    .COORD_BITS(32),
    .FRAC_BITS (FRAC)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // predictor state
  logic [tvb_pkg::REG_W-1:0] mat_regs    [tvb_pkg::NUM_REGS];
  logic signed [31:0]        low_corner  [tvb_pkg::AXES];
  logic signed [31:0]        high_corner [tvb_pkg::AXES];
  box_t                      pending_boxes [$];

  logic [tvb_pkg::REG_W-1:0] mat_sets [3][tvb_pkg::NUM_REGS];
  string field_names [6] = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};

  int fail_count  = 0;
  int quiet       = 0;
  int burst_left  = 0;
  int stall_run   = 0;
  bit stall_now   = 1'b0;
  bit tx_gaps_on  = 1'b1;
  bit rx_stall_on = 1'b1;

  // identity matrix rows first, then the saturating all-max and all-min matrices
  row_t directed_rows [17] = '{
    '{'{'{1'b0, 1'b1}, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 0, 1'b1, '0},
    '{'{'{1'b1, 1'b0}, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF}, 0, 1'b0, '0},
    '{'{'{1'b0, 1'b1}, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000}, 0, 1'b1,
      '{32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
        32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000}},
    '{'{'{1'b1, 1'b1}, 32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000}, 0, 1'b1,
      '{32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000,
        32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000}},
    '{'{'{1'b0, 1'b0}, 32'h7FFF_0000, 32'h0000_0001, 32'hFFFF_8000}, 0, 1'b0, '0},
    '{'{'{1'b0, 1'b1}, 32'h0000_0000, 32'hAAAA_5555, 32'h5555_AAAA}, 0, 1'b0, '0},
    '{'{'{1'b1, 1'b0}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0, 1'b0, '0},
    '{'{'{1'b1, 1'b1}, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 0, 1'b1, '0},
    '{'{'{1'b0, 1'b1}, 32'h0F0F_0F0F, 32'h9ABC_DEF0, 32'h1234_5678}, 0, 1'b0, '0},
    '{'{'{1'b1, 1'b1}, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1, 1'b1,
      '{default: 32'h7FFF_FFFF}},
    '{'{'{1'b1, 1'b1}, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1, 1'b1,
      '{default: 32'h8000_0000}},
    '{'{'{1'b1, 1'b0}, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001}, 1, 1'b0, '0},
    '{'{'{1'b0, 1'b1}, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000}, 1, 1'b0, '0},
    '{'{'{1'b1, 1'b1}, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 2, 1'b0, '0},
    '{'{'{1'b0, 1'b0}, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 2, 1'b0, '0},
    '{'{'{1'b0, 1'b1}, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 2, 1'b0, '0},
    '{'{'{1'b1, 1'b1}, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000}, 2, 1'b0, '0}
  };

  function automatic void open_bounds();
    for (int a = 0; a < tvb_pkg::AXES; a++) begin
      low_corner[a]  = 32'sh7FFF_FFFF;
      high_corner[a] = 32'sh8000_0000;
    end
  endfunction

  // exact sum of products, floor from Q16.16 to an integer, clamp to 32 signed bits
  function automatic logic signed [31:0] transform_axis(logic [63:0] c01, logic [63:0] c23,
                                                        vertex_t v);
    logic signed [79:0] m0, m1, m2, m3, px, py, pz, acc;
    m0  = $signed(c01[31:0]);
    m1  = $signed(c01[63:32]);
    m2  = $signed(c23[31:0]);
    m3  = $signed(c23[63:32]);
    px  = $signed(v.x);
    py  = $signed(v.y);
    pz  = $signed(v.z);
    acc = m0 * px + m1 * py + m2 * pz + (m3 <<< FRAC);
    acc = acc >>> FRAC;
    if (acc > SAT_HI) return SAT_HI[31:0];
    if (acc < SAT_LO) return SAT_LO[31:0];
    return acc[31:0];
  endfunction

  function automatic box_t widen_bounds(vertex_t v);
    logic signed [31:0] t;
    box_t b;
    if (v.flags.first) open_bounds();
    for (int a = 0; a < tvb_pkg::AXES; a++) begin
      t = transform_axis(mat_regs[2*a], mat_regs[2*a+1], v);
      if (t < low_corner[a]) low_corner[a] = t;
      if (t > high_corner[a]) high_corner[a] = t;
    end
    b.min_x = low_corner[0];
    b.min_y = low_corner[1];
    b.min_z = low_corner[2];
    b.max_x = high_corner[0];
    b.max_y = high_corner[1];
    b.max_z = high_corner[2];
    return b;
  endfunction

  function automatic vertex_t random_vertex(logic first, logic last);
    vertex_t v;
    logic [31:0] c [3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 9))
        0:       c[i] = 32'h7FFF_FFFF;
        1:       c[i] = 32'h8000_0000;
        2, 3, 4: c[i] = $urandom();
        default: c[i] = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      endcase
    end
    v.flags.first = first;
    v.flags.last  = last;
    v.x = c[0];
    v.y = c[1];
    v.z = c[2];
    return v;
  endfunction

  // stop sending, let every pending box arrive, then let the pipeline drain
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_boxes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_matrix(logic [tvb_pkg::REG_W-1:0] regs [tvb_pkg::NUM_REGS]);
    settle_idle();
    for (int i = 0; i < tvb_pkg::NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= tvb_pkg::REG_IDX_W'(i);
      cfg_data  <= regs[i];
      @(posedge clk);
      mat_regs[i] = regs[i];
    end
    // an index past the register list must leave the matrix alone
    cfg_index <= tvb_pkg::REG_IDX_W'(tvb_pkg::NUM_REGS +
                 $urandom_range(0, (1 << tvb_pkg::REG_IDX_W) - 1 - tvb_pkg::NUM_REGS));
    cfg_data  <= {$urandom(), $urandom()};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_vertex(vertex_t v, bit typed, box_t typed_box);
    box_t b;
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v.z, v.y, v.x};
    s_axis_tuser  <= v.flags.first;
    s_axis_tlast  <= v.flags.last;
    do @(posedge clk); while (!s_axis_tready);
    b = widen_bounds(v);
    if (typed) b = typed_box;
    if (v.flags.last) pending_boxes = {pending_boxes, b};
    if (tx_gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = $urandom_range(1, 16);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_run = $urandom_range(1, 24);
      stall_now = rx_stall_on && ($urandom_range(0, 2) == 0);
    end else begin
      stall_run--;
    end
    m_axis_tready <= !stall_now;
  end

  always @(posedge clk) begin : result_check
    box_t want;
    logic [191:0] want_bits;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_boxes.size() == 0) begin
        fail_count++;
        $error("bounds transfer with no vertex run pending");
      end else begin
        want = pending_boxes.pop_front();
        want_bits = want;
        for (int i = 0; i < 6; i++) begin
          if (m_axis_tdata[32*i +: 32] !== want_bits[32*i +: 32]) begin
            fail_count++;
            $error("%s expected %h actual %h", field_names[i],
                   want_bits[32*i +: 32], m_axis_tdata[32*i +: 32]);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("transformed_vertex_bounds verification failed");
      $finish;
    end
  end

  initial begin
    logic [tvb_pkg::REG_W-1:0] new_regs [tvb_pkg::NUM_REGS];
    logic [31:0] word;
    int cur_mat;
    int phase_items;
    int mesh_len;

    mat_sets[0] = tvb_pkg::REG_RESET;
    mat_sets[1] = '{default: 64'h7FFF_FFFF_7FFF_FFFF};
    mat_sets[2] = '{default: 64'h8000_0000_8000_0000};
    mat_regs    = tvb_pkg::REG_RESET;
    open_bounds();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    cur_mat = 0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].mat != cur_mat) begin
        cur_mat = directed_rows[i].mat;
        load_matrix(mat_sets[cur_mat]);
      end
      send_vertex(directed_rows[i].v, directed_rows[i].typed, directed_rows[i].box);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      for (int i = 0; i < 2 * tvb_pkg::NUM_REGS; i++) begin
        case (ph % 4)
          2: word = $urandom();
          3: begin
            case ($urandom_range(0, 4))
              0:       word = 32'h7FFF_FFFF;
              1:       word = 32'h8000_0000;
              2:       word = 32'h0000_0000;
              3:       word = 32'h0001_0000;
              default: word = 32'hFFFF_0000;
            endcase
          end
          // coefficients within +-4.0 keep most sums in range
          default: word = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
        new_regs[i/2][32*(i%2) +: 32] = word;
      end
      load_matrix(new_regs);
      tx_gaps_on  = (ph % 3 != 2);
      rx_stall_on = (ph % 4 != 1);

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          send_vertex(random_vertex(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
                      1'b0, '0);
          phase_items++;
        end else begin
          mesh_len = $urandom_range(1, 12);
          for (int k = 0; k < mesh_len; k++)
            send_vertex(random_vertex(k == 0, k == mesh_len - 1), 1'b0, '0);
          phase_items += mesh_len;
          if ($urandom_range(0, 59) == 0) settle_idle();
        end
      end
    end

    settle_idle();
    if (fail_count == 0)
      $display("transformed_vertex_bounds verification clean");
    else
      $display("transformed_vertex_bounds verification failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/tvb_pkg.sv
rtl/tvb_xform.sv
rtl/tvb_fifo.sv
rtl/tvb_bounds.sv
rtl/transformed_vertex_bounds.sv
dv/tb.sv
